// ----- src/tsm_pkg.sv -----
package tsm_pkg;

  // Field widths of the stream payloads and the register port.
  localparam int unsigned TempW  = 15;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned DeltaW = 14;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;
  localparam int unsigned InW    = 56;
  localparam int unsigned OutW   = 8;

  // Register map, one word per register.
  typedef enum logic [2:0] {
    REG_SAFE_LOW       = 3'd0,
    REG_SAFE_HIGH      = 3'd1,
    REG_HEAT_TARGET    = 3'd2,
    REG_SENSOR_TIMEOUT = 3'd3,
    REG_HEAT_WINDOW    = 3'd4,
    REG_HEAT_MIN_RISE  = 3'd5,
    REG_COOL_WINDOW    = 3'd6,
    REG_COOL_MIN_DROP  = 3'd7
  } reg_idx_e;

  // Evaluation kinds carried in tuser.
  localparam logic KIND_SAFETY = 1'b0;
  localparam logic KIND_EFFECT = 1'b1;

  // Band direction codes.
  localparam logic [1:0] DIR_IN    = 2'b00;
  localparam logic [1:0] DIR_ABOVE = 2'b01;
  localparam logic [1:0] DIR_BELOW = 2'b11;
  localparam logic [1:0] DIR_BAD   = 2'b10;

  // Register reset values.
  localparam logic signed [TempW-1:0] SAFE_LOW_RST    = 15'sd2200;
  localparam logic signed [TempW-1:0] SAFE_HIGH_RST   = 15'sd3000;
  localparam logic signed [TempW-1:0] HEAT_TARGET_RST = 15'sd2500;
  localparam logic [TimeW-1:0]        SENSOR_TMO_RST  = 32'd10000;
  localparam logic [TimeW-1:0]        WINDOW_RST      = 32'd600000;
  localparam logic [DeltaW-1:0]       MIN_DELTA_RST   = 14'd10;

  // One evaluation as it sits in the input register.
  typedef struct packed {
    logic                    kind;
    logic [TimeW-1:0]        now_ms;
    logic signed [TempW-1:0] water_temp;
    logic                    water_valid;
    logic                    heater_on;
    logic                    fan_running;
    logic                    fan_rpm_fault;
  } item_t;

endpackage

// ----- src/thermal_safety_monitor.sv -----
// Thermal safety monitor.
// Evaluations arrive on the s_axis channel: tuser carries the kind (safety or
// effectiveness) and tdata the timestamp, temperature and status flags. Every
// transfer in gives exactly one transfer out on the m_axis channel, carrying the
// band direction and the sensor, heater, fan and overall alarm flags.
// Thresholds and window lengths are set through the APB port; the user must
// set them only while the block is idle, as the block itself does not enforce
// this. Reads return the current register values. An input transfer loads
// the input register, and when the item advances the evaluation logic updates
// the state and result registers together. Throughput is one item per cycle
// while the receiver does not stall, set by the single register stage between
// the input register and the result flags.
// When the receiver stalls, the result is held and one further item waits in
// the input register; s_axis_tready then falls until the result is taken.
// Reset clears all state, the flags and both valid bits, and loads the
// register defaults; the block is ready for items as soon as reset is released.
module thermal_safety_monitor (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Input stream.
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // tdata: now_ms[31:0], water_temp[46:32], water_valid[47], heater_on[48],
  // fan_running[49], fan_rpm_fault[50], zero fill[55:51].
  input  logic [tsm_pkg::InW-1:0]     s_axis_tdata_i,
  // tuser: kind[0].
  input  logic                        s_axis_tuser_i,
  // Result stream.
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // tdata: alarm_dir[1:0], sensor_fault[2], heat_fault[3], cool_fault[4],
  // alarm[5], zero fill[7:6].
  output logic [tsm_pkg::OutW-1:0]    m_axis_tdata_o,
  // Register port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tsm_pkg::AddrW-1:0]   paddr,
  input  logic [tsm_pkg::DataW-1:0]   pwdata,
  output logic [tsm_pkg::DataW-1:0]   prdata,
  output logic                        pready
);

  localparam int unsigned TempW  = tsm_pkg::TempW;
  localparam int unsigned TimeW  = tsm_pkg::TimeW;
  localparam int unsigned DeltaW = tsm_pkg::DeltaW;
  localparam int unsigned DiffW  = TempW + 2;

  // Configuration registers.
  logic signed [TempW-1:0] safe_low_q, safe_high_q, heat_target_q;
  logic [TimeW-1:0]        sensor_timeout_q, heat_window_q, cool_window_q;
  logic [DeltaW-1:0]       heat_min_rise_q, cool_min_drop_q;

  tsm_pkg::reg_idx_e reg_idx;
  logic              cfg_wr;

  assign reg_idx = tsm_pkg::reg_idx_e'(paddr[tsm_pkg::AddrW-1:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      safe_low_q       <= tsm_pkg::SAFE_LOW_RST;
      safe_high_q      <= tsm_pkg::SAFE_HIGH_RST;
      heat_target_q    <= tsm_pkg::HEAT_TARGET_RST;
      sensor_timeout_q <= tsm_pkg::SENSOR_TMO_RST;
      heat_window_q    <= tsm_pkg::WINDOW_RST;
      heat_min_rise_q  <= tsm_pkg::MIN_DELTA_RST;
      cool_window_q    <= tsm_pkg::WINDOW_RST;
      cool_min_drop_q  <= tsm_pkg::MIN_DELTA_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        tsm_pkg::REG_SAFE_LOW:       safe_low_q       <= pwdata[TempW-1:0];
        tsm_pkg::REG_SAFE_HIGH:      safe_high_q      <= pwdata[TempW-1:0];
        tsm_pkg::REG_HEAT_TARGET:    heat_target_q    <= pwdata[TempW-1:0];
        tsm_pkg::REG_SENSOR_TIMEOUT: sensor_timeout_q <= pwdata[TimeW-1:0];
        tsm_pkg::REG_HEAT_WINDOW:    heat_window_q    <= pwdata[TimeW-1:0];
        tsm_pkg::REG_HEAT_MIN_RISE:  heat_min_rise_q  <= pwdata[DeltaW-1:0];
        tsm_pkg::REG_COOL_WINDOW:    cool_window_q    <= pwdata[TimeW-1:0];
        tsm_pkg::REG_COOL_MIN_DROP:  cool_min_drop_q  <= pwdata[DeltaW-1:0];
        default: ;
      endcase
    end
  end

  // Register reads; signed thresholds read back sign-extended.
  always_comb begin
    case (reg_idx)
      tsm_pkg::REG_SAFE_LOW:       prdata = 32'(signed'(safe_low_q));
      tsm_pkg::REG_SAFE_HIGH:      prdata = 32'(signed'(safe_high_q));
      tsm_pkg::REG_HEAT_TARGET:    prdata = 32'(signed'(heat_target_q));
      tsm_pkg::REG_SENSOR_TIMEOUT: prdata = sensor_timeout_q;
      tsm_pkg::REG_HEAT_WINDOW:    prdata = heat_window_q;
      tsm_pkg::REG_HEAT_MIN_RISE:  prdata = 32'(heat_min_rise_q);
      tsm_pkg::REG_COOL_WINDOW:    prdata = cool_window_q;
      tsm_pkg::REG_COOL_MIN_DROP:  prdata = 32'(cool_min_drop_q);
      default:                     prdata = '0;
    endcase
  end

  // Input register and handshake. The item moves on once the result slot is
  // free or is being emptied in the same cycle.
  tsm_pkg::item_t item_q;
  logic           item_vld_q;
  logic           out_vld_q;
  logic           advance;

  assign advance         = item_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !item_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      item_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      item_q.kind          <= s_axis_tuser_i;
      item_q.now_ms        <= s_axis_tdata_i[31:0];
      item_q.water_temp    <= s_axis_tdata_i[46:32];
      item_q.water_valid   <= s_axis_tdata_i[47];
      item_q.heater_on     <= s_axis_tdata_i[48];
      item_q.fan_running   <= s_axis_tdata_i[49];
      item_q.fan_rpm_fault <= s_axis_tdata_i[50];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // Monitor state; the flags double as the result register.
  logic                    started_q, started_d;
  logic [TimeW-1:0]        last_valid_q, last_valid_d;
  logic                    heat_open_q, heat_open_d;
  logic [TimeW-1:0]        heat_t0_q, heat_t0_d;
  logic signed [TempW-1:0] heat_temp0_q, heat_temp0_d;
  logic                    cool_open_q, cool_open_d;
  logic [TimeW-1:0]        cool_t0_q, cool_t0_d;
  logic signed [TempW-1:0] cool_temp0_q, cool_temp0_d;
  logic                    heat_fault_q, heat_fault_d;
  logic                    cool_fault_q, cool_fault_d;
  logic [1:0]              dir_q, dir_d;
  logic                    timeout_q, timeout_d;
  logic                    alarm_q, alarm_d;

  // Intermediate values of the evaluation.
  logic [TimeW-1:0]        lv_base;
  logic                    heat_cond, cool_cond;
  logic signed [DiffW-1:0] rise, drop;

  always_comb begin
    started_d    = started_q;
    last_valid_d = last_valid_q;
    heat_open_d  = heat_open_q;
    heat_t0_d    = heat_t0_q;
    heat_temp0_d = heat_temp0_q;
    cool_open_d  = cool_open_q;
    cool_t0_d    = cool_t0_q;
    cool_temp0_d = cool_temp0_q;
    heat_fault_d = heat_fault_q;
    cool_fault_d = cool_fault_q;
    dir_d        = dir_q;
    timeout_d    = timeout_q;
    alarm_d      = alarm_q;

    lv_base   = started_q ? last_valid_q : item_q.now_ms;
    heat_cond = item_q.water_valid && item_q.heater_on &&
                (item_q.water_temp < heat_target_q);
    cool_cond = item_q.water_valid && item_q.fan_running;
    rise      = DiffW'(item_q.water_temp) - DiffW'(heat_temp0_q);
    drop      = DiffW'(cool_temp0_q) - DiffW'(item_q.water_temp);

    if (item_q.kind == tsm_pkg::KIND_SAFETY) begin
      // Band check, sensor timeout and the overall alarm.
      dir_d = tsm_pkg::DIR_IN;
      if (item_q.water_valid) begin
        if (item_q.water_temp > safe_high_q) begin
          dir_d = tsm_pkg::DIR_ABOVE;
        end else if (item_q.water_temp < safe_low_q) begin
          dir_d = tsm_pkg::DIR_BELOW;
        end
      end
      started_d    = 1'b1;
      last_valid_d = item_q.water_valid ? item_q.now_ms : lv_base;
      timeout_d    = (item_q.now_ms - last_valid_d) >= sensor_timeout_q;
      alarm_d      = (dir_d != tsm_pkg::DIR_IN) || timeout_d || heat_fault_q ||
                     cool_fault_q || item_q.fan_rpm_fault;
    end else begin
      // Heater watch window.
      if (heat_cond) begin
        if (!heat_open_q) begin
          heat_open_d  = 1'b1;
          heat_t0_d    = item_q.now_ms;
          heat_temp0_d = item_q.water_temp;
        end else if ((item_q.now_ms - heat_t0_q) >= heat_window_q) begin
          heat_fault_d = !(rise >= signed'(DiffW'(heat_min_rise_q)));
          heat_t0_d    = item_q.now_ms;
          heat_temp0_d = item_q.water_temp;
        end
      end else begin
        heat_open_d  = 1'b0;
        heat_fault_d = 1'b0;
      end
      // Fan watch window.
      if (cool_cond) begin
        if (!cool_open_q) begin
          cool_open_d  = 1'b1;
          cool_t0_d    = item_q.now_ms;
          cool_temp0_d = item_q.water_temp;
        end else if ((item_q.now_ms - cool_t0_q) >= cool_window_q) begin
          cool_fault_d = !(drop >= signed'(DiffW'(cool_min_drop_q)));
          cool_t0_d    = item_q.now_ms;
          cool_temp0_d = item_q.water_temp;
        end
      end else begin
        cool_open_d  = 1'b0;
        cool_fault_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q    <= 1'b0;
      last_valid_q <= '0;
      heat_open_q  <= 1'b0;
      heat_t0_q    <= '0;
      heat_temp0_q <= '0;
      cool_open_q  <= 1'b0;
      cool_t0_q    <= '0;
      cool_temp0_q <= '0;
      heat_fault_q <= 1'b0;
      cool_fault_q <= 1'b0;
      dir_q        <= tsm_pkg::DIR_IN;
      timeout_q    <= 1'b0;
      alarm_q      <= 1'b0;
    end else if (advance) begin
      started_q    <= started_d;
      last_valid_q <= last_valid_d;
      heat_open_q  <= heat_open_d;
      heat_t0_q    <= heat_t0_d;
      heat_temp0_q <= heat_temp0_d;
      cool_open_q  <= cool_open_d;
      cool_t0_q    <= cool_t0_d;
      cool_temp0_q <= cool_temp0_d;
      heat_fault_q <= heat_fault_d;
      cool_fault_q <= cool_fault_d;
      dir_q        <= dir_d;
      timeout_q    <= timeout_d;
      alarm_q      <= alarm_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {2'b00, alarm_q, cool_fault_q, heat_fault_q, timeout_q, dir_q};

endmodule

// ----- src/tsm_checker.sv -----
module tsm_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     m_axis_tvalid_o,
  input logic                     m_axis_tready_i,
  input logic [tsm_pkg::OutW-1:0] m_axis_tdata_o
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // The direction field never carries the unused code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[1:0] != tsm_pkg::DIR_BAD)
    else $error("invalid band direction");

  // Direction, timeout and alarm come from the same safety item, so a clear
  // alarm implies an in-band reading and no sensor fault.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[5] |->
      m_axis_tdata_o[1:0] == tsm_pkg::DIR_IN && !m_axis_tdata_o[2])
    else $error("alarm clear despite band or sensor fault");

  // Fill bits of the result stay zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[7:6] == 2'b00)
    else $error("result fill bits set");

endmodule

bind thermal_safety_monitor tsm_checker u_tsm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// ----- tb/sv/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // One result transfer as it sits in m_axis_tdata, lowest field last.
  typedef struct packed {
    logic [1:0] fill;
    logic       alarm;
    logic       cool_fault;
    logic       heat_fault;
    logic       sensor_fault;
    logic [1:0] alarm_dir;
  } flags_t;

  logic                      clk_i           = 1'b0;
  logic                      rst_ni          = 1'b0;
  logic                      s_axis_tvalid_i = 1'b0;
  logic                      s_axis_tready_o;
  logic [tsm_pkg::InW-1:0]   s_axis_tdata_i  = '0;
  logic                      s_axis_tuser_i  = 1'b0;
  logic                      m_axis_tvalid_o;
  logic                      m_axis_tready_i = 1'b1;
  logic [tsm_pkg::OutW-1:0]  m_axis_tdata_o;
  logic                      psel            = 1'b0;
  logic                      penable         = 1'b0;
  logic                      pwrite          = 1'b0;
  logic [tsm_pkg::AddrW-1:0] paddr           = '0;
  logic [tsm_pkg::DataW-1:0] pwdata          = '0;
  logic [tsm_pkg::DataW-1:0] prdata;
  logic                      pready;

  thermal_safety_monitor i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Mirror of the register file.
  int          band_low   = tsm_pkg::SAFE_LOW_RST;
  int          band_high  = tsm_pkg::SAFE_HIGH_RST;
  int          heat_goal  = tsm_pkg::HEAT_TARGET_RST;
  logic [31:0] sensor_tmo = tsm_pkg::SENSOR_TMO_RST;
  logic [31:0] heat_win   = tsm_pkg::WINDOW_RST;
  logic [31:0] cool_win   = tsm_pkg::WINDOW_RST;
  int          min_rise   = tsm_pkg::MIN_DELTA_RST;
  int          min_drop   = tsm_pkg::MIN_DELTA_RST;

  // Mirror of the monitor state.
  bit          seen_safety;
  logic [31:0] last_valid_ms;
  bit          heat_open;
  bit          cool_open;
  logic [31:0] heat_t0_ms;
  logic [31:0] cool_t0_ms;
  int          heat_t0_temp;
  int          cool_t0_temp;
  bit          heat_fault;
  bit          cool_fault;
  bit          sensor_fault;
  bit          alarm_flag;
  logic [1:0]  band_dir = tsm_pkg::DIR_IN;

  flags_t      expected_q[$];
  int          errors;
  int          items_sent;
  int          results_seen;
  int          heat_hits;
  int          cool_hits;
  int          sensor_hits;
  int          alarm_hits;
  int          calm_left;
  int          hold_left;
  logic [31:0] clock_ms;
  int          water;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Works out the flags that one evaluation leaves behind.
  function automatic flags_t evaluate(tsm_pkg::item_t it);
    int          temp;
    logic [31:0] span;
    flags_t      res;
    temp = {{17{it.water_temp[tsm_pkg::TempW-1]}}, it.water_temp};
    if (it.kind == tsm_pkg::KIND_SAFETY) begin
      band_dir = tsm_pkg::DIR_IN;
      if (it.water_valid) begin
        if (temp > band_high) begin
          band_dir = tsm_pkg::DIR_ABOVE;
        end else if (temp < band_low) begin
          band_dir = tsm_pkg::DIR_BELOW;
        end
      end
      if (!seen_safety) begin
        last_valid_ms = it.now_ms;
        seen_safety   = 1'b1;
      end
      if (it.water_valid) last_valid_ms = it.now_ms;
      span         = it.now_ms - last_valid_ms;
      sensor_fault = (span >= sensor_tmo);
      alarm_flag   = (band_dir != tsm_pkg::DIR_IN) || sensor_fault || heat_fault ||
                     cool_fault || it.fan_rpm_fault;
    end else begin
      // Heater window: only runs while the water is below the heater target.
      if (it.water_valid && it.heater_on && temp < heat_goal) begin
        span = it.now_ms - heat_t0_ms;
        if (!heat_open) begin
          heat_open    = 1'b1;
          heat_t0_ms   = it.now_ms;
          heat_t0_temp = temp;
        end else if (span >= heat_win) begin
          heat_fault   = !((temp - heat_t0_temp) >= min_rise);
          heat_t0_ms   = it.now_ms;
          heat_t0_temp = temp;
        end
      end else begin
        heat_open  = 1'b0;
        heat_fault = 1'b0;
      end
      // Fan window.
      if (it.water_valid && it.fan_running) begin
        span = it.now_ms - cool_t0_ms;
        if (!cool_open) begin
          cool_open    = 1'b1;
          cool_t0_ms   = it.now_ms;
          cool_t0_temp = temp;
        end else if (span >= cool_win) begin
          cool_fault   = !((cool_t0_temp - temp) >= min_drop);
          cool_t0_ms   = it.now_ms;
          cool_t0_temp = temp;
        end
      end else begin
        cool_open  = 1'b0;
        cool_fault = 1'b0;
      end
    end
    res.fill         = '0;
    res.alarm_dir    = band_dir;
    res.sensor_fault = sensor_fault;
    res.heat_fault   = heat_fault;
    res.cool_fault   = cool_fault;
    res.alarm        = alarm_flag;
    return res;
  endfunction

  function automatic tsm_pkg::item_t make_eval(logic kind, logic [31:0] now, int temp,
                                               logic valid, logic heater, logic fan,
                                               logic rpm);
    tsm_pkg::item_t it;
    it.kind          = kind;
    it.now_ms        = now;
    it.water_temp    = temp[tsm_pkg::TempW-1:0];
    it.water_valid   = valid;
    it.heater_on     = heater;
    it.fan_running   = fan;
    it.fan_rpm_fault = rpm;
    return it;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Result side: checks each transfer and draws a fresh stall after it.
  always @(posedge clk_i) begin
    flags_t got;
    flags_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("result transfer with no evaluation outstanding: %h", got);
        errors++;
      end else begin
        want = expected_q.pop_front();
        check_field("alarm_dir", want.alarm_dir, got.alarm_dir);
        check_field("sensor_fault", want.sensor_fault, got.sensor_fault);
        check_field("heat_fault", want.heat_fault, got.heat_fault);
        check_field("cool_fault", want.cool_fault, got.cool_fault);
        check_field("alarm", want.alarm, got.alarm);
        check_field("fill", want.fill, got.fill);
      end
      heat_hits   += got.heat_fault;
      cool_hits   += got.cool_fault;
      sensor_hits += got.sensor_fault;
      alarm_hits  += got.alarm;
      hold_left = (calm_left > 0) ? 0 : $urandom_range(0, 19);
    end else if (hold_left > 0) begin
      hold_left--;
    end
    m_axis_tready_i <= (hold_left == 0);
  end

  // Sends one evaluation; tvalid is left high so that back-to-back transfers need no gap.
  task automatic send_item(tsm_pkg::item_t it);
    int gap;
    if (calm_left > 0) begin
      calm_left--;
    end else if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(10, 40);
    end
    gap = (calm_left > 0) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= it.kind;
    s_axis_tdata_i  <= {5'b0, it.fan_rpm_fault, it.fan_running, it.heater_on,
                        it.water_valid, it.water_temp, it.now_ms};
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_q.push_back(evaluate(it));
    items_sent++;
  endtask

  // Holds off the input until every outstanding result has been taken.
  task automatic wait_drain();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (expected_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Reads a register back and compares the implemented bits with the mirror.
  task automatic verify_reg(tsm_pkg::reg_idx_e r);
    logic [31:0] want;
    logic [31:0] mask;
    logic [31:0] got;
    case (r)
      tsm_pkg::REG_SAFE_LOW:       begin want = band_low;   mask = 32'h0000_7FFF; end
      tsm_pkg::REG_SAFE_HIGH:      begin want = band_high;  mask = 32'h0000_7FFF; end
      tsm_pkg::REG_HEAT_TARGET:    begin want = heat_goal;  mask = 32'h0000_7FFF; end
      tsm_pkg::REG_SENSOR_TIMEOUT: begin want = sensor_tmo; mask = 32'hFFFF_FFFF; end
      tsm_pkg::REG_HEAT_WINDOW:    begin want = heat_win;   mask = 32'hFFFF_FFFF; end
      tsm_pkg::REG_HEAT_MIN_RISE:  begin want = min_rise;   mask = 32'h0000_3FFF; end
      tsm_pkg::REG_COOL_WINDOW:    begin want = cool_win;   mask = 32'hFFFF_FFFF; end
      default:                     begin want = min_drop;   mask = 32'h0000_3FFF; end
    endcase
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {r, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if ((got & mask) != (want & mask)) begin
      $error("register %s: expected %h, got %h", r.name(), want & mask, got & mask);
      errors++;
    end
  endtask

  // Writes a register, updates the mirror and reads it back.
  task automatic cfg_write(tsm_pkg::reg_idx_e r, logic [31:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (r)
      tsm_pkg::REG_SAFE_LOW:
        band_low   = {{17{v[tsm_pkg::TempW-1]}}, v[tsm_pkg::TempW-1:0]};
      tsm_pkg::REG_SAFE_HIGH:
        band_high  = {{17{v[tsm_pkg::TempW-1]}}, v[tsm_pkg::TempW-1:0]};
      tsm_pkg::REG_HEAT_TARGET:
        heat_goal  = {{17{v[tsm_pkg::TempW-1]}}, v[tsm_pkg::TempW-1:0]};
      tsm_pkg::REG_SENSOR_TIMEOUT: sensor_tmo = v;
      tsm_pkg::REG_HEAT_WINDOW:    heat_win   = v;
      tsm_pkg::REG_HEAT_MIN_RISE:  min_rise   = int'(v[tsm_pkg::DeltaW-1:0]);
      tsm_pkg::REG_COOL_WINDOW:    cool_win   = v;
      default:                     min_drop   = int'(v[tsm_pkg::DeltaW-1:0]);
    endcase
    verify_reg(r);
  endtask

  task automatic test_register_defaults();
    for (int i = 0; i < 8; i++) verify_reg(tsm_pkg::reg_idx_e'(i));
  endtask

  // Band edges, field extremes, the timeout threshold, a failed fan window and
  // the wrap of the millisecond counter, all at reset settings.
  task automatic test_directed();
    send_item(make_eval(tsm_pkg::KIND_SAFETY, 32'd0, 0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(make_eval(tsm_pkg::KIND_SAFETY, 32'd9999, 0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(make_eval(tsm_pkg::KIND_SAFETY, 32'd10000, 0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(make_eval(tsm_pkg::KIND_SAFETY, 32'd10001, 2200, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(make_eval(tsm_pkg::KIND_SAFETY, 32'd10002, 2199, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(make_eval(tsm_pkg::KIND_SAFETY, 32'd10003, 3000, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(make_eval(tsm_pkg::KIND_SAFETY, 32'd10004, 3001, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(make_eval(tsm_pkg::KIND_SAFETY, 32'd10005, -16384, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(make_eval(tsm_pkg::KIND_SAFETY, 32'd10006, 16383, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(make_eval(tsm_pkg::KIND_SAFETY, 32'd10007, 16383, 1'b0, 1'b0, 1'b0, 1'b1));
    // Open both windows; the heater one closes at its target, the fan one fails.
    send_item(make_eval(tsm_pkg::KIND_EFFECT, 32'd20000, 2499, 1'b1, 1'b1, 1'b1, 1'b0));
    send_item(make_eval(tsm_pkg::KIND_EFFECT, 32'd620000, 2508, 1'b1, 1'b1, 1'b1, 1'b0));
    send_item(make_eval(tsm_pkg::KIND_SAFETY, 32'd620001, 2500, 1'b1, 1'b0, 1'b0, 1'b0));
    // Reaching the heater target closes its window; an invalid reading closes both.
    send_item(make_eval(tsm_pkg::KIND_EFFECT, 32'd620002, 2500, 1'b1, 1'b1, 1'b1, 1'b0));
    send_item(make_eval(tsm_pkg::KIND_EFFECT, 32'd620003, 2500, 1'b0, 1'b1, 1'b1, 1'b0));
    send_item(make_eval(tsm_pkg::KIND_SAFETY, 32'hFFFF_FFFF, 2500, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(make_eval(tsm_pkg::KIND_SAFETY, 32'h0000_0010, 2500, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(make_eval(tsm_pkg::KIND_EFFECT, 32'hFFFF_FFFF, -1, 1'b1, 1'b1, 1'b1, 1'b1));
  endtask

  // Zero sensor timeout and a crossed band.
  task automatic test_limit_settings();
    wait_drain();
    cfg_write(tsm_pkg::REG_SENSOR_TIMEOUT, 32'd0);
    send_item(make_eval(tsm_pkg::KIND_SAFETY, 32'd100, 2500, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(make_eval(tsm_pkg::KIND_SAFETY, 32'd100, 2500, 1'b0, 1'b0, 1'b0, 1'b0));
    wait_drain();
    cfg_write(tsm_pkg::REG_SAFE_LOW, 32'd100);
    cfg_write(tsm_pkg::REG_SAFE_HIGH, -100);
    send_item(make_eval(tsm_pkg::KIND_SAFETY, 32'd200, 0, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(make_eval(tsm_pkg::KIND_SAFETY, 32'd201, -200, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(make_eval(tsm_pkg::KIND_SAFETY, 32'd202, 200, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(make_eval(tsm_pkg::KIND_SAFETY, 32'd203, -100, 1'b1, 1'b0, 1'b0, 1'b0));
  endtask

  // Mostly safety items near the band edges, with short and maximal sensor timeouts.
  task automatic test_band_random();
    tsm_pkg::item_t it;
    int             edge_val;
    int             d;
    for (int ph = 0; ph < 5; ph++) begin
      wait_drain();
      case (ph)
        0: begin
          cfg_write(tsm_pkg::REG_SAFE_LOW, tsm_pkg::SAFE_LOW_RST);
          cfg_write(tsm_pkg::REG_SAFE_HIGH, tsm_pkg::SAFE_HIGH_RST);
          cfg_write(tsm_pkg::REG_SENSOR_TIMEOUT, 32'd500);
        end
        1: begin
          cfg_write(tsm_pkg::REG_SAFE_LOW, -16384);
          cfg_write(tsm_pkg::REG_SAFE_HIGH, 16383);
          cfg_write(tsm_pkg::REG_SENSOR_TIMEOUT, 32'hFFFF_FFFF);
        end
        2: begin
          cfg_write(tsm_pkg::REG_SAFE_LOW, 16383);
          cfg_write(tsm_pkg::REG_SAFE_HIGH, -16384);
          cfg_write(tsm_pkg::REG_SENSOR_TIMEOUT, 32'd200);
        end
        default: begin
          cfg_write(tsm_pkg::REG_SAFE_LOW, $urandom_range(0, 9000) - 3000);
          cfg_write(tsm_pkg::REG_SAFE_HIGH, $urandom_range(0, 9000) - 3000);
          cfg_write(tsm_pkg::REG_SENSOR_TIMEOUT, $urandom_range(0, 600));
        end
      endcase
      for (int i = 0; i < 30; i++) begin
        clock_ms += $urandom_range(0, 200);
        if ($urandom_range(0, 1) == 0) begin
          d = $urandom_range(0, 32767) - 16384;
        end else begin
          edge_val = ($urandom_range(0, 1) == 0) ? band_low : band_high;
          d = $urandom_range(0, 6);
          d = edge_val + d - 3;
        end
        it = make_eval(($urandom_range(0, 3) == 0) ? tsm_pkg::KIND_EFFECT
                                                   : tsm_pkg::KIND_SAFETY,
                       clock_ms, d,
                       $urandom_range(0, 2) != 0, 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)),
                       $urandom_range(0, 7) == 0);
        send_item(it);
      end
    end
  endtask

  // Runs of effectiveness evaluations with the water drifting towards the
  // direction the active actuator should push it, broken now and then.
  task automatic drive_window_run(bit cooling, int count);
    tsm_pkg::item_t it;
    int             step;
    for (int i = 0; i < count; i++) begin
      clock_ms += $urandom_range(0, 150);
      step = $urandom_range(0, 12);
      water += cooling ? (3 - step) : (step - 3);
      if (water > 12000 || water < -5000) water = $urandom_range(0, 4000);
      it = make_eval(($urandom_range(0, 3) == 0) ? tsm_pkg::KIND_SAFETY
                                                 : tsm_pkg::KIND_EFFECT,
                     clock_ms, water,
                     $urandom_range(0, 15) != 0,
                     cooling ? logic'($urandom_range(0, 1)) : logic'($urandom_range(0, 15) != 0),
                     cooling ? logic'($urandom_range(0, 15) != 0) : logic'($urandom_range(0, 1)),
                     $urandom_range(0, 7) == 0);
      send_item(it);
    end
  endtask

  task automatic test_heater_windows();
    logic [31:0] win;
    int          rise;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       begin win = 32'd0;        rise = 0;     end
        1:       begin win = 32'd1;        rise = 16383; end
        2:       begin win = 32'hFFFF_FFFF; rise = 10;   end
        default: begin win = $urandom_range(20, 400); rise = $urandom_range(0, 30); end
      endcase
      wait_drain();
      cfg_write(tsm_pkg::REG_HEAT_WINDOW, win);
      cfg_write(tsm_pkg::REG_HEAT_MIN_RISE, rise);
      cfg_write(tsm_pkg::REG_HEAT_TARGET, (ph == 5) ? 2500 : 12500);
      water = (ph == 5) ? 2450 : 1000;
      drive_window_run(1'b0, 30);
    end
  endtask

  task automatic test_fan_windows();
    logic [31:0] win;
    int          drop;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       begin win = 32'd0;        drop = 0;     end
        1:       begin win = 32'd1;        drop = 16383; end
        2:       begin win = 32'hFFFF_FFFF; drop = 10;   end
        default: begin win = $urandom_range(20, 400); drop = $urandom_range(0, 30); end
      endcase
      wait_drain();
      cfg_write(tsm_pkg::REG_COOL_WINDOW, win);
      cfg_write(tsm_pkg::REG_COOL_MIN_DROP, drop);
      water = 6000;
      drive_window_run(1'b1, 30);
    end
  endtask

  // Unrestricted field values under random settings, across the counter wrap
  // and with jumping timestamps; the sender pauses once for a full drain.
  task automatic test_mixed_random();
    tsm_pkg::item_t it;
    for (int ph = 0; ph < 4; ph++) begin
      wait_drain();
      cfg_write(tsm_pkg::REG_SAFE_LOW, $urandom_range(0, 32767) - 16384);
      cfg_write(tsm_pkg::REG_SAFE_HIGH, $urandom_range(0, 32767) - 16384);
      cfg_write(tsm_pkg::REG_HEAT_TARGET, $urandom_range(0, 32767) - 16384);
      cfg_write(tsm_pkg::REG_SENSOR_TIMEOUT, $urandom_range(0, 3000));
      cfg_write(tsm_pkg::REG_HEAT_WINDOW, $urandom_range(0, 3000));
      cfg_write(tsm_pkg::REG_HEAT_MIN_RISE, $urandom_range(0, 16383));
      cfg_write(tsm_pkg::REG_COOL_WINDOW, $urandom_range(0, 3000));
      cfg_write(tsm_pkg::REG_COOL_MIN_DROP, $urandom_range(0, 16383));
      if (ph == 2) clock_ms = 32'hFFFF_FE00;
      for (int i = 0; i < 55; i++) begin
        if (ph == 1 && i == 27) wait_drain();
        if (ph == 3) begin
          clock_ms = $urandom();
        end else begin
          clock_ms += $urandom_range(0, 500);
        end
        it = make_eval(1'($urandom_range(0, 1)), clock_ms, $urandom_range(0, 32767),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        send_item(it);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_defaults();
    test_directed();
    test_limit_settings();
    test_band_random();
    test_heater_windows();
    test_fan_windows();
    test_mixed_random();
    wait_drain();
    repeat (10) @(posedge clk_i);
    $display("Checked %0d evaluations against %0d result transfers over all eight registers.",
             items_sent, results_seen);
    $display("Flags raised: heater %0d, fan %0d, sensor %0d, overall alarm %0d.",
             heat_hits, cool_hits, sensor_hits, alarm_hits);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/tsm_pkg.sv
src/thermal_safety_monitor.sv
src/tsm_checker.sv
tb/sv/testbench.sv
